// ===== hw/rtl/arf_pkg.sv =====
// arf_pkg: shared types and constants of the advertising report filter
// no dependencies; used by every module of the block and by the checker

package arf_pkg;

  // field widths fixed by the port definition
  localparam int KEY_W     = 56;
  localparam int ADDR_W    = 48;
  localparam int KIND_W    = 8;
  localparam int SLOT_W    = 3;
  localparam int COUNT_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // default list depth (1 to 8)
  localparam int LIST_DEPTH_DEF = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_APPEAR_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_APPEAR_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UUID_A   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UUID_B   = 2'd3;

  // configuration reset values
  localparam logic [CFG_W-1:0] APPEAR_A_RST = 16'h03C1;
  localparam logic [CFG_W-1:0] APPEAR_B_RST = 16'h03C5;
  localparam logic [CFG_W-1:0] UUID_A_RST   = 16'h18F0;
  localparam logic [CFG_W-1:0] UUID_B_RST   = 16'hFF00;

  // advertising data structure types
  localparam logic [7:0] AD_TYPE_UUID16_MORE = 8'h02;
  localparam logic [7:0] AD_TYPE_UUID16_FULL = 8'h03;
  localparam logic [7:0] AD_TYPE_APPEARANCE  = 8'h19;

  // result outcome codes
  localparam logic [1:0] OC_NONE   = 2'd0;
  localparam logic [1:0] OC_STORED = 2'd1;
  localparam logic [1:0] OC_LISTED = 2'd2;
  localparam logic [1:0] OC_FULL   = 2'd3;

  // top level sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  // search token walking the cell chain
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } token_t;

  // list write request from the sequencer
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
  } list_wr_t;

  // per-byte control for the parser
  typedef struct packed {
    logic step;
    logic clear;
    logic first;
    logic last;
    logic legacy;
  } parse_ctrl_t;

endpackage

// ===== hw/rtl/adv_report_filter_dedup_unit.sv =====
// adv_report_filter_dedup_unit: advertising report filter with address de-duplication
// depends on arf_pkg, arf_parser, arf_chain (arf_cell)
//
//   channel | direction | signals                                   | handshake
//   input   | in        | cmd ad_byte first_byte last_byte is_legacy | in_valid / in_ready
//           |           | peer_address peer_address_kind            |
//   result  | out       | report_matched outcome slot_index         | out_valid / out_ready
//           |           | list_count                                |
//   config  | in        | cfg_index cfg_data                        | cfg_we, no wait
//
// payload bytes, clear commands and final bytes of unmatched reports need no search
// a matched final byte starts a search that holds off all input: the key walks the cell
// chain one slot per cycle, the list is updated and the result loaded at the tail
// a final byte is held off while an earlier result still sits in the output register
// rst is synchronous; the address list itself is not cleared, the fill count guards it

module adv_report_filter_dedup_unit
  import arf_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  logic [7:0]           ad_byte,
  input  logic                 first_byte,
  input  logic                 last_byte,
  input  logic                 is_legacy,
  input  logic [ADDR_W-1:0]    peer_address,
  input  logic [KIND_W-1:0]    peer_address_kind,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 report_matched,
  output logic [1:0]           outcome,
  output logic [SLOT_W-1:0]    slot_index,
  output logic [COUNT_W-1:0]   list_count
);

  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(LIST_DEPTH);

  state_t             state;
  state_t             state_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;

  logic        in_xfer;
  logic        byte_xfer;
  logic        match_next;
  logic        launch;
  logic        tail_done;
  logic        out_load;
  logic        out_slot_free;
  parse_ctrl_t pctrl;
  token_t      tok_head;
  token_t      tok_tail;
  list_wr_t    wr;

  logic              res_matched;
  logic [1:0]        res_outcome;
  logic [SLOT_W-1:0] res_slot;

  assign out_slot_free = !out_valid || out_ready;
  assign in_xfer       = in_valid && in_ready;
  assign byte_xfer     = in_xfer && !cmd;
  assign tail_done     = tok_tail.valid;

  // parser control
  assign pctrl.step   = byte_xfer;
  assign pctrl.clear  = in_xfer && cmd;
  assign pctrl.first  = first_byte;
  assign pctrl.last   = last_byte;
  assign pctrl.legacy = is_legacy;

  arf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (pctrl),
    .ad_byte   (ad_byte),
    .match_next(match_next)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (launch) state_next = ST_SEARCH;
      ST_SEARCH: if (tail_done) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    case (state)
      ST_IDLE:   in_ready = cmd || !last_byte || out_slot_free;
      ST_SEARCH: in_ready = 1'b0;
      default:   in_ready = 1'b0;
    endcase
  end

  assign launch = byte_xfer && last_byte && match_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // search token into the head of the chain
  assign tok_head.valid = launch;
  assign tok_head.key   = {peer_address_kind, peer_address};
  assign tok_head.found = 1'b0;
  assign tok_head.slot  = '0;

  arf_chain #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .count   (count),
    .wr      (wr),
    .tok_head(tok_head),
    .tok_tail(tok_tail)
  );

  // list update and result at the tail of the search, fill count cleared on a clear command
  always_comb begin
    wr.en       = 1'b0;
    wr.slot     = count[SLOT_W-1:0];
    wr.key      = tok_tail.key;
    count_next  = count;
    res_matched = 1'b0;
    res_outcome = OC_NONE;
    res_slot    = '0;
    if (tail_done) begin
      res_matched = 1'b1;
      if (tok_tail.found) begin
        res_outcome = OC_LISTED;
        res_slot    = tok_tail.slot;
      end else if (count < DEPTH_CNT) begin
        wr.en       = 1'b1;
        res_outcome = OC_STORED;
        res_slot    = count[SLOT_W-1:0];
        count_next  = count + COUNT_W'(1);
      end else begin
        res_outcome = OC_FULL;
      end
    end else if (in_xfer && cmd) begin
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else     count <= count_next;
  end

  // output register
  assign out_load = tail_done || (byte_xfer && last_byte && !match_next);

  always_ff @(posedge clk) begin
    if (rst)            out_valid <= 1'b0;
    else if (out_load)  out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      report_matched <= res_matched;
      outcome        <= res_outcome;
      slot_index     <= res_slot;
      list_count     <= count_next;
    end
  end

endmodule

// ===== hw/rtl/arf_parser.sv =====
// arf_parser: length-type-value walker with appearance and uuid match test
// depends on arf_pkg; holds the four match configuration registers

module arf_parser
  import arf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  parse_ctrl_t          ctrl,
  input  logic [7:0]           ad_byte,
  output logic                 match_next
);

  logic [CFG_W-1:0] appear_a;
  logic [CFG_W-1:0] appear_b;
  logic [CFG_W-1:0] uuid_a;
  logic [CFG_W-1:0] uuid_b;

  logic [7:0] offset;
  logic [7:0] length;
  logic [7:0] ad_type;
  logic [7:0] low_byte;
  logic       match_seen;

  logic [7:0] base_offset;
  logic [7:0] base_length;
  logic [7:0] base_type;
  logic [7:0] base_low;
  logic       base_match;

  logic [7:0] offset_next;
  logic [7:0] length_next;
  logic [7:0] type_next;
  logic [7:0] low_next;
  logic       match_seen_next;

  logic [15:0] value;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      appear_a <= APPEAR_A_RST;
      appear_b <= APPEAR_B_RST;
      uuid_a   <= UUID_A_RST;
      uuid_b   <= UUID_B_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_APPEAR_A: appear_a <= cfg_data;
        CFG_APPEAR_B: appear_b <= cfg_data;
        CFG_UUID_A:   uuid_a   <= cfg_data;
        CFG_UUID_B:   uuid_b   <= cfg_data;
        default:      appear_a <= appear_a;
      endcase
    end
  end

  // parser state as seen by this byte, restarted on a first byte
  always_comb begin
    if (ctrl.first) begin
      base_offset = '0;
      base_length = '0;
      base_type   = '0;
      base_low    = '0;
      base_match  = 1'b0;
    end else begin
      base_offset = offset;
      base_length = length;
      base_type   = ad_type;
      base_low    = low_byte;
      base_match  = match_seen;
    end
  end

  assign value = {ad_byte, base_low};

  // one step of the structure walk
  always_comb begin
    offset_next     = base_offset;
    length_next     = base_length;
    type_next       = base_type;
    low_next        = base_low;
    match_seen_next = base_match;
    if (ctrl.legacy && !base_match) begin
      if (base_offset == 8'd0) begin
        // length byte; a zero length structure is skipped
        length_next = ad_byte;
        offset_next = (ad_byte != 8'd0) ? 8'd1 : 8'd0;
      end else begin
        case (base_offset)
          8'd1: type_next = ad_byte;
          8'd2: low_next  = ad_byte;
          8'd3: begin
            // second value byte inside the structure: test the value
            if (base_type == AD_TYPE_APPEARANCE) begin
              if (value == appear_a || value == appear_b) match_seen_next = 1'b1;
            end else if (base_type == AD_TYPE_UUID16_MORE ||
                         base_type == AD_TYPE_UUID16_FULL) begin
              if (value == uuid_a || value == uuid_b) match_seen_next = 1'b1;
            end
          end
          default: low_next = base_low;
        endcase
        offset_next = (base_offset >= base_length) ? 8'd0 : base_offset + 8'd1;
      end
    end
  end

  assign match_next = match_seen_next;

  // parser registers, cleared on clear command and after a last byte
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear || (ctrl.step && ctrl.last)) begin
      offset     <= '0;
      length     <= '0;
      ad_type    <= '0;
      low_byte   <= '0;
      match_seen <= 1'b0;
    end else if (ctrl.step) begin
      offset     <= offset_next;
      length     <= length_next;
      ad_type    <= type_next;
      low_byte   <= low_next;
      match_seen <= match_seen_next;
    end
  end

endmodule

// ===== hw/rtl/arf_cell.sv =====
// arf_cell: one address list slot with its compare stage
// depends on arf_pkg; passes the search token to the next cell each cycle

module arf_cell
  import arf_pkg::*;
#(
  parameter int CELL_INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [COUNT_W-1:0] count,
  input  list_wr_t           wr,
  input  token_t             tok_in,
  output token_t             tok_out
);

  localparam logic [SLOT_W-1:0]  MY_SLOT  = SLOT_W'(CELL_INDEX);
  localparam logic [COUNT_W-1:0] MY_COUNT = COUNT_W'(CELL_INDEX);

  logic [KEY_W-1:0] entry;
  logic             hit;

  // stored address, written when the sequencer appends to this slot
  always_ff @(posedge clk) begin
    if (wr.en && wr.slot == MY_SLOT) entry <= wr.key;
  end

  // only slots below the fill count hold a listed address
  assign hit = (count > MY_COUNT) && (entry == tok_in.key);

  // token stage, only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) tok_out.valid <= 1'b0;
    else     tok_out.valid <= tok_in.valid;
    tok_out.key   <= tok_in.key;
    tok_out.found <= tok_in.found || hit;
    tok_out.slot  <= tok_in.found ? tok_in.slot : MY_SLOT;
  end

endmodule

// ===== hw/rtl/arf_chain.sv =====
// arf_chain: row of address list cells, the token walks one cell a cycle
// depends on arf_pkg and arf_cell

module arf_chain
  import arf_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [COUNT_W-1:0] count,
  input  list_wr_t           wr,
  input  token_t             tok_head,
  output token_t             tok_tail
);

  token_t tok [0:LIST_DEPTH];

  assign tok[0]   = tok_head;
  assign tok_tail = tok[LIST_DEPTH];

  // one cell per list slot
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    arf_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .count  (count),
      .wr     (wr),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
  end

endmodule

// ===== hw/rtl/arf_checker.sv =====
// arf_checker: port level checks of the advertising report filter
// depends on arf_pkg; bound to adv_report_filter_dedup_unit at the end of this file

module arf_checker
  import arf_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               report_matched,
  input logic [1:0]         outcome,
  input logic [SLOT_W-1:0]  slot_index,
  input logic [COUNT_W-1:0] list_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(slot_index)
                                && $stable(list_count) && $stable(report_matched))
    else $error("result changed while stalled");

  // list never holds more than its depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> list_count <= COUNT_W'(LIST_DEPTH))
    else $error("list count above depth");

  // matched flag agrees with the outcome
  a_match_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (report_matched == (outcome != OC_NONE)))
    else $error("matched flag and outcome disagree");

  // no slot reported without a store or a hit
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == OC_NONE || outcome == OC_FULL) |-> slot_index == '0)
    else $error("slot index given without slot");

  // a new entry goes to the last filled slot
  a_store_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OC_STORED |->
      COUNT_W'(slot_index) + COUNT_W'(1) == list_count)
    else $error("stored slot does not match list count");

endmodule

bind adv_report_filter_dedup_unit arf_checker #(
  .LIST_DEPTH(LIST_DEPTH)
) u_arf_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .report_matched(report_matched),
  .outcome       (outcome),
  .slot_index    (slot_index),
  .list_count    (list_count)
);
